// ===== sv/pre_pkg.sv =====
// ----------------------------------------------------------------------------
// pre_pkg
// Shared constants and types of the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

    localparam int MAX_RUN   = 32;
    localparam int RC_W      = $clog2(MAX_RUN + 1);
    localparam int HB_AW     = $clog2(MAX_RUN);
    localparam int BYTE_W    = 8;
    localparam int MINRUN_W  = 6;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int QDEPTH    = 4;
    localparam int QP_W      = $clog2(QDEPTH);

    localparam logic [BYTE_W-1:0]    PRINT_LO       = 8'h20;
    localparam logic [BYTE_W-1:0]    PRINT_HI       = 8'h7E;
    localparam logic [MINRUN_W-1:0]  MIN_RUN_RESET  = 6'd4;
    localparam logic [BYTE_W-1:0]    SEP_RESET      = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              emit;
        logic              rel;
        logic              sep;
        logic [RC_W-1:0]   count;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [HB_AW-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic rel_done;
    } t_back_stat;

endpackage

// ===== sv/pre_in_if.sv =====
// ----------------------------------------------------------------------------
// pre_in_if
// Input channel: one raw buffer byte per word.
// ----------------------------------------------------------------------------
interface pre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_buffer;

    modport source(output valid, output data_byte, output last_in_buffer, input ready);
    modport sink(input valid, input data_byte, input last_in_buffer, output ready);
endinterface

// ===== sv/pre_out_if.sv =====
// ----------------------------------------------------------------------------
// pre_out_if
// Output channel: one string byte, separator or end marker per word.
// ----------------------------------------------------------------------------
interface pre_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_end_marker;
    logic [15:0] out_length;
    logic        last_of_item;

    modport source(output valid, output out_byte, output is_end_marker,
                   output out_length, output last_of_item, input ready);
    modport sink(input valid, input out_byte, input is_end_marker,
                 input out_length, input last_of_item, output ready);
endinterface

// ===== sv/pre_ram.sv =====
// ----------------------------------------------------------------------------
// pre_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/pre_front.sv =====
// ----------------------------------------------------------------------------
// pre_front
// Classifies each input byte, tracks the printable run and queues commands.
// ----------------------------------------------------------------------------
module pre_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pre_pkg::MINRUN_W-1:0] i_min_run,
    pre_in_if.sink                    i_in,
    output logic                      o_push,
    output pre_pkg::t_cmd             o_cmd,
    input  logic                      i_q_full,
    output pre_pkg::t_ram_wr          o_ram_wr,
    input  pre_pkg::t_back_stat       i_stat
);
    import pre_pkg::*;

    logic [RC_W-1:0] r_run, n_run;
    logic            r_pass, n_pass;
    logic            r_seen, n_seen;
    logic            r_busy, n_busy;
    logic [RC_W-1:0] w_eff;
    logic            w_accept;
    logic            w_print;
    logic            w_release;
    t_cmd            w_cmd;
    t_ram_wr         w_wr;

    assign i_in.ready = !r_busy && !i_q_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_print    = (i_in.data_byte >= PRINT_LO) && (i_in.data_byte <= PRINT_HI);

    always_comb begin
        if (i_min_run == '0) begin
            w_eff = RC_W'(1);
        end else if (int'(i_min_run) > MAX_RUN) begin
            w_eff = RC_W'(MAX_RUN);
        end else begin
            w_eff = RC_W'(i_min_run);
        end
    end

    assign w_release = ({1'b0, r_run} + (RC_W + 1)'(1)) >= {1'b0, w_eff};

    always_comb begin
        n_run      = r_run;
        n_pass     = r_pass;
        n_seen     = r_seen;
        n_busy     = r_busy;
        w_cmd      = '0;
        w_cmd.data = i_in.data_byte;
        w_wr       = '0;
        w_wr.data  = i_in.data_byte;
        w_wr.addr  = r_run[HB_AW-1:0];
        if (i_stat.rel_done) begin
            n_busy = 1'b0;
        end
        if (w_accept) begin
            if (w_print) begin
                if (r_pass) begin
                    w_cmd.emit = 1'b1;
                end else if (w_release) begin
                    w_cmd.emit  = 1'b1;
                    w_cmd.rel   = 1'b1;
                    w_cmd.sep   = r_seen;
                    w_cmd.count = r_run;
                    n_seen      = 1'b1;
                    n_pass      = 1'b1;
                    n_run       = '0;
                    n_busy      = 1'b1;
                end else if (int'(r_run) < MAX_RUN) begin
                    w_wr.we = 1'b1;
                    n_run   = r_run + RC_W'(1);
                end
            end else begin
                n_run  = '0;
                n_pass = 1'b0;
            end
            if (i_in.last_in_buffer) begin
                w_cmd.last = 1'b1;
                n_run      = '0;
                n_pass     = 1'b0;
                n_seen     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_pass <= 1'b0;
            r_seen <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_pass <= n_pass;
            r_seen <= n_seen;
            r_busy <= n_busy;
        end
    end

    assign o_push   = w_accept && (w_cmd.emit || w_cmd.last);
    assign o_cmd    = w_cmd;
    assign o_ram_wr = w_wr;
endmodule

// ===== sv/pre_queue.sv =====
// ----------------------------------------------------------------------------
// pre_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pre_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pre_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pre_pkg::t_cmd o_head
);
    import pre_pkg::*;

    t_cmd            r_mem [QDEPTH];
    logic [QP_W-1:0] r_wp, r_rp;
    logic [QP_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QP_W'(QDEPTH - 1)) ? '0 : r_wp + QP_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QP_W'(QDEPTH - 1)) ? '0 : r_rp + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QP_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QP_W + 1)'(1);
            end
        end
    end

    assign o_full  = (r_cnt == (QP_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
endmodule

// ===== sv/pre_back.sv =====
// ----------------------------------------------------------------------------
// pre_back
// Executes queued commands and drives the registered output channel.
// ----------------------------------------------------------------------------
module pre_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pre_pkg::BYTE_W-1:0] i_separator,
    input  logic                       i_q_valid,
    input  pre_pkg::t_cmd              i_q_head,
    output logic                       o_q_pop,
    output logic [pre_pkg::HB_AW-1:0]  o_raddr,
    input  logic [pre_pkg::BYTE_W-1:0] i_rdata,
    output pre_pkg::t_back_stat        o_stat,
    pre_out_if.source                  o_out
);
    import pre_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SEP  = 6'b000010,
        S_HRD  = 6'b000100,
        S_HWR  = 6'b001000,
        S_BYTE = 6'b010000,
        S_END  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [RC_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_end;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;
    logic              w_can_load;
    logic              w_load;
    logic [BYTE_W-1:0] w_byte;
    logic              w_end;
    logic [LEN_W-1:0]  w_len;
    logic              w_last;
    t_back_stat        w_stat;

    function automatic t_state first_state(t_cmd c);
        t_state s;
        if (c.rel && c.sep) begin
            s = S_SEP;
        end else if (c.rel && (c.count != '0)) begin
            s = S_HRD;
        end else if (c.emit) begin
            s = S_BYTE;
        end else begin
            s = S_END;
        end
        return s;
    endfunction

    assign w_can_load = !r_out_valid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        o_q_pop  = 1'b0;
        w_load   = 1'b0;
        w_byte   = '0;
        w_end    = 1'b0;
        w_len    = '0;
        w_last   = 1'b0;
        w_stat   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_idx   = '0;
                    n_state = first_state(i_q_head);
                end
            end
            S_SEP: begin
                if (w_can_load) begin
                    w_load  = 1'b1;
                    w_byte  = i_separator;
                    n_state = (r_cmd.count != '0) ? S_HRD : S_BYTE;
                end
            end
            S_HRD: begin
                n_state = S_HWR;
            end
            S_HWR: begin
                if (w_can_load) begin
                    w_load  = 1'b1;
                    w_byte  = i_rdata;
                    n_idx   = r_idx + RC_W'(1);
                    n_state = (n_idx == r_cmd.count) ? S_BYTE : S_HRD;
                end
            end
            S_BYTE: begin
                if (w_can_load) begin
                    w_load          = 1'b1;
                    w_byte          = r_cmd.data;
                    w_last          = !r_cmd.last;
                    w_stat.rel_done = r_cmd.rel;
                    n_state         = r_cmd.last ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (w_can_load) begin
                    w_load  = 1'b1;
                    w_end   = 1'b1;
                    w_len   = r_cnt;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_load) begin
            if (w_end) begin
                n_cnt = '0;
            end else if (r_cnt != '1) begin
                n_cnt = r_cnt + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (w_load) begin
            r_out_byte <= w_byte;
            r_out_end  <= w_end;
            r_out_len  <= w_len;
            r_out_last <= w_last;
        end
    end

    assign o_raddr             = r_idx[HB_AW-1:0];
    assign o_stat              = w_stat;
    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.is_end_marker = r_out_end;
    assign o_out.out_length    = r_out_len;
    assign o_out.last_of_item  = r_out_last;

    a_end_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && w_load) |=> (r_cnt == '0))
        else $error("Byte count not cleared after end marker.");

    a_held_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HWR) |-> (r_idx < r_cmd.count))
        else $error("Held byte index beyond the run length.");

    a_sep_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEP) |-> (r_cmd.rel && r_cmd.sep))
        else $error("Separator emitted outside a release.");
endmodule

// ===== sv/printable_run_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// printable_run_extractor_unit
// Passes on runs of printable bytes that reach the minimum run length.
// ----------------------------------------------------------------------------
// A byte that is held, dropped or passed through is taken as long as the
// command queue has room. The back end handles a pass-through byte with a
// command pop, then an output load, and an end marker with one more load.
// When a run reaches the minimum length, the front stops taking bytes until
// the back end has emitted the whole run: the separator if one is due, each
// held byte by a registered read of the held-byte memory and a load, then
// the releasing byte. The output is registered and emits at most one word a cycle.
module printable_run_extractor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pre_pkg::CFG_DAT_W-1:0] i_cfg_data,
    pre_in_if.sink                        i_in,
    pre_out_if.source                     o_out
);
    import pre_pkg::*;

    logic [MINRUN_W-1:0] r_min_run;
    logic [BYTE_W-1:0]   r_separator;
    logic                w_push;
    t_cmd                w_cmd;
    logic                w_full;
    logic                w_pop;
    logic                w_q_valid;
    t_cmd                w_head;
    t_ram_wr             w_ram_wr;
    logic [HB_AW-1:0]    w_raddr;
    logic [BYTE_W-1:0]   w_rdata;
    t_back_stat          w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run   <= MIN_RUN_RESET;
            r_separator <= SEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_RUN:   r_min_run   <= i_cfg_data[MINRUN_W-1:0];
                REG_SEPARATOR: r_separator <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pre_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_RUN)
    ) u_held (
        .i_clk   (i_clk),
        .i_we    (w_ram_wr.we),
        .i_waddr (w_ram_wr.addr),
        .i_wdata (w_ram_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pre_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_run (r_min_run),
        .i_in      (i_in),
        .o_push    (w_push),
        .o_cmd     (w_cmd),
        .i_q_full  (w_full),
        .o_ram_wr  (w_ram_wr),
        .i_stat    (w_stat)
    );

    pre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    pre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_separator (r_separator),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );
endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the printable run extractor. Bytes are driven on the
// input channel with random gaps and the output channel is stalled at random.
// Every accepted word goes through a local model of the extractor, and each
// output word is compared field by field with the oldest predicted word. The
// run covers directed edge cases, several register settings including the
// extremes, a change of the minimum run length in the middle of a run, and a
// stretch of one buffer driven at full rate with no idling on either side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pre_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int IDLE_PCT    = 34;
    localparam int SETTLE      = 2 * MAX_RUN + 16;
    localparam int CALM_BYTES  = 40;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_in_buffer;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_end_marker;
        logic [LEN_W-1:0]  out_length;
        logic              last_of_item;
    } t_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    pre_in_if  in_ch();
    pre_out_if out_ch();

    printable_run_extractor_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    t_item             byte_q[$];
    t_word             pending_words[$];
    t_word             staged[$];
    t_item             next_item;
    t_word             want;
    logic              in_took;
    logic              calm;
    int unsigned       mismatches;
    int unsigned       cycle_cnt;

    // Local copy of the extractor state and its registers.
    logic [MINRUN_W-1:0] cur_min_run;
    logic [BYTE_W-1:0]   cur_sep;
    logic [BYTE_W-1:0]   held_buf[MAX_RUN];
    int unsigned         held_len;
    logic                in_string;
    logic                seen_string;
    logic [LEN_W-1:0]    out_count;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic stage_byte(input logic [BYTE_W-1:0] b);
        staged.push_back('{out_byte: b, is_end_marker: 1'b0, out_length: '0,
                           last_of_item: 1'b0});
        if (out_count != {LEN_W{1'b1}})
            out_count++;
    endtask

    task automatic extract_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned eff;
        t_word       tail;
        staged.delete();
        eff = cur_min_run;
        if (eff < 1)
            eff = 1;
        if (eff > MAX_RUN)
            eff = MAX_RUN;
        if (b >= PRINT_LO && b <= PRINT_HI) begin
            if (in_string) begin
                stage_byte(b);
            end else if (held_len + 1 >= eff) begin
                if (seen_string)
                    stage_byte(cur_sep);
                for (int k = 0; k < held_len; k++)
                    stage_byte(held_buf[k]);
                stage_byte(b);
                seen_string = 1'b1;
                in_string   = 1'b1;
                held_len    = 0;
            end else if (held_len < MAX_RUN) begin
                held_buf[held_len] = b;
                held_len++;
            end
        end else begin
            held_len  = 0;
            in_string = 1'b0;
        end
        if (last) begin
            staged.push_back('{out_byte: '0, is_end_marker: 1'b1,
                               out_length: out_count, last_of_item: 1'b0});
            held_len    = 0;
            in_string   = 1'b0;
            seen_string = 1'b0;
            out_count   = '0;
        end
        if (staged.size() != 0) begin
            tail = staged.pop_back();
            tail.last_of_item = 1'b1;
            staged.push_back(tail);
        end
        foreach (staged[k])
            pending_words.push_back(staged[k]);
    endtask

    // Input side: note each accepted word and predict what it causes.
    always @(posedge i_clk) begin
        in_took <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready)
            extract_byte(in_ch.data_byte, in_ch.last_in_buffer);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item = byte_q.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.data_byte      <= next_item.data_byte;
                in_ch.last_in_buffer <= next_item.last_in_buffer;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: out_byte %0h end %0b length %0d",
                       out_ch.out_byte, out_ch.is_end_marker, out_ch.out_length);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                if (out_ch.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte,
                           out_ch.out_byte);
                    mismatches++;
                end
                if (out_ch.is_end_marker !== want.is_end_marker) begin
                    $error("is_end_marker: expected %0b, got %0b", want.is_end_marker,
                           out_ch.is_end_marker);
                    mismatches++;
                end
                if (out_ch.out_length !== want.out_length) begin
                    $error("out_length: expected %0d, got %0d", want.out_length,
                           out_ch.out_length);
                    mismatches++;
                end
                if (out_ch.last_of_item !== want.last_of_item) begin
                    $error("last_of_item: expected %0b, got %0b", want.last_of_item,
                           out_ch.last_of_item);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_MIN_RUN)
            cur_min_run = val[MINRUN_W-1:0];
        else
            cur_sep = val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [MINRUN_W-1:0] run_len,
                            input logic [BYTE_W-1:0] sep);
        write_reg(REG_MIN_RUN, CFG_DAT_W'(run_len));
        write_reg(REG_SEPARATOR, sep);
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
        byte_q.push_back('{data_byte: b, last_in_buffer: last});
    endtask

    function automatic logic [BYTE_W-1:0] pick_control();
        return $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 31))
                                    : BYTE_W'($urandom_range(127, 255));
    endfunction

    // Mostly runs of printable text broken by control bytes, with some noise.
    task automatic gen_buffers(input int n_items, input int max_len);
        int pushed;
        int len;
        int kind;
        pushed = 0;
        while (pushed < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_byte(BYTE_W'($urandom()), $urandom_range(0, 19) == 0);
                pushed++;
            end else begin
                len  = $urandom_range(0, max_len);
                kind = $urandom_range(0, 3);
                for (int k = 0; k < len; k++) begin
                    queue_byte(BYTE_W'($urandom_range(PRINT_LO, PRINT_HI)),
                               kind == 0 && k == len - 1);
                    pushed++;
                end
                if (kind != 0 || len == 0) begin
                    queue_byte(pick_control(), kind == 1);
                    pushed++;
                end
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (byte_q.size() != 0 || in_ch.valid || pending_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.last_in_buffer = 1'b0;
        out_ch.ready         = 1'b0;
        in_took              = 1'b0;
        calm                 = 1'b0;
        mismatches           = 0;
        cycle_cnt            = 0;
        cur_min_run          = MIN_RUN_RESET;
        cur_sep              = SEP_RESET;
        held_len             = 0;
        in_string            = 1'b0;
        seen_string          = 1'b0;
        out_count            = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: printable bounds, a first string without separator,
        // a second with one, a short run dropped at the end and an empty buffer.
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h7E, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b0);
        queue_byte(8'h43, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h63, 1'b0);
        queue_byte(8'h64, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h30, 1'b0);
        queue_byte(8'h31, 1'b1);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        set_regs(6'd1, 8'h00);
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7E, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h21, 1'b1);
        gen_buffers(30, 6);
        wait_idle();

        // Longest run length; the phase ends with a run still being held.
        set_regs(6'd32, 8'hFF);
        gen_buffers(30, 40);
        queue_byte(8'h0A, 1'b0);
        for (int k = 0; k < 10; k++)
            queue_byte(BYTE_W'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0);
        wait_idle();

        // Lowering the length mid-run releases the held bytes on the next one.
        set_regs(6'd2, BYTE_W'($urandom()));
        queue_byte(8'h5A, 1'b0);
        gen_buffers(40, 6);
        wait_idle();

        set_regs(6'd0, BYTE_W'($urandom()));
        gen_buffers(30, 5);
        wait_idle();

        set_regs(6'd63, BYTE_W'($urandom()));
        gen_buffers(30, 40);
        wait_idle();

        for (int p = 0; p < 2; p++) begin
            set_regs(MINRUN_W'($urandom_range(3, 8)), BYTE_W'($urandom()));
            gen_buffers(30, 12);
            wait_idle();
        end

        // One buffer at full rate with no idling on either side.
        set_regs(6'd1, 8'h2E);
        calm <= 1'b1;
        for (int k = 0; k < CALM_BYTES; k++)
            queue_byte(BYTE_W'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0);
        queue_byte(8'h41, 1'b1);
        wait_idle();
        calm <= 1'b0;
        repeat (SETTLE) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
